// ===== rtl/core/hns_pkg.sv =====
// Shared types and codes for the held note stack.
`default_nettype none
package hns_pkg;

   localparam int NOTE_W = 7;
   localparam int COUNT_OUT_W = 5;

   // Event codes on req_action
   localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
   localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
   localparam logic [1:0] ACT_CLEAR    = 2'd2;

   // One stored key
   typedef struct packed {
      logic              used;
      logic [NOTE_W-1:0] note;
      logic [NOTE_W-1:0] velocity;
   } entry_type;

   // Running pitch range over a tail of the chain
   typedef struct packed {
      logic              any;
      logic [NOTE_W-1:0] lo;
      logic [NOTE_W-1:0] hi;
   } range_type;

   // Command broadcast from the sequencer to every cell
   typedef struct packed {
      logic              do_match;
      logic              do_clear;
      logic              do_shift;
      logic              do_push;
      logic [NOTE_W-1:0] key;
      logic [NOTE_W-1:0] velocity;
   } cell_cmd_type;

   // Result transaction
   typedef struct packed {
      logic                   valid;
      logic [COUNT_OUT_W-1:0] held_count;
      logic                   is_empty;
      logic [NOTE_W-1:0]      recent_note;
      logic [NOTE_W-1:0]      recent_velocity;
      logic [NOTE_W-1:0]      lowest_note;
      logic [NOTE_W-1:0]      highest_note;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/held_note_stack.sv =====
// Top level of the held note stack: sequencer plus a chain of note cells.
//
//  Channel  | Ports                                  | Handshake
//  ---------+----------------------------------------+------------------------------
//  request  | req_action, req_note, req_velocity     | taken when start=1, busy=0
//  response | rsp_held_count .. rsp_highest_note     | rsp_valid one cycle, no stall
//
// Cells sit in recency order, most recent at slot 0. An event steps through
// a match step, the gap walk along the chain, a push (note on only), then the
// settle steps while the pitch range ripples to slot 0, before the done state
// registers the rsp_valid strobe. Synchronous reset empties the chain at once.
// The response is never held back; busy stays high for the whole event.
`default_nettype none
module held_note_stack #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_action,
   input  wire logic [hns_pkg::NOTE_W-1:0] req_note,
   input  wire logic [hns_pkg::NOTE_W-1:0] req_velocity,
   output logic                            rsp_valid,
   output logic [hns_pkg::COUNT_OUT_W-1:0] rsp_held_count,
   output logic                            rsp_is_empty,
   output logic [hns_pkg::NOTE_W-1:0]      rsp_recent_note,
   output logic [hns_pkg::NOTE_W-1:0]      rsp_recent_velocity,
   output logic [hns_pkg::NOTE_W-1:0]      rsp_lowest_note,
   output logic [hns_pkg::NOTE_W-1:0]      rsp_highest_note
);

   hns_pkg::cell_cmd_type cmd;
   hns_pkg::rsp_type      rsp;
   hns_pkg::entry_type    entries [STACK_DEPTH];
   hns_pkg::range_type    ranges  [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] holes;
   logic [STACK_DEPTH-1:0] hits;
   hns_pkg::entry_type    new_entry;

   assign new_entry = '{used: 1'b1, note: cmd.key, velocity: cmd.velocity};

   hns_ctrl #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .action     (req_action),
      .note       (req_note),
      .velocity   (req_velocity),
      .hit_any    (|hits),
      .head       (entries[0]),
      .head_range (ranges[0]),
      .busy       (busy),
      .cmd        (cmd),
      .rsp        (rsp)
   );

   // Cell chain: new notes enter at slot 0, gaps travel toward the tail and ranges flow from it
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      hns_pkg::entry_type left_entry;
      logic               left_hole;
      hns_pkg::entry_type right_entry;
      hns_pkg::range_type right_range;

      if (i == 0) begin : g_head
         assign left_entry = new_entry;
         assign left_hole  = 1'b0;
      end else begin : g_body
         assign left_entry = entries[i-1];
         assign left_hole  = holes[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_tail
         assign right_entry = '0;
         assign right_range = '0;
      end else begin : g_mid
         assign right_entry = entries[i+1];
         assign right_range = ranges[i+1];
      end

      hns_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_hole   (left_hole),
         .right_entry (right_entry),
         .right_range (right_range),
         .entry       (entries[i]),
         .hole        (holes[i]),
         .range       (ranges[i]),
         .hit         (hits[i])
      );
   end

   assign rsp_valid           = rsp.valid;
   assign rsp_held_count      = rsp.held_count;
   assign rsp_is_empty        = rsp.is_empty;
   assign rsp_recent_note     = rsp.recent_note;
   assign rsp_recent_velocity = rsp.recent_velocity;
   assign rsp_lowest_note     = rsp.lowest_note;
   assign rsp_highest_note    = rsp.highest_note;

endmodule
`default_nettype wire

// ===== rtl/core/hns_cell.sv =====
// One slot of the recency chain with its share of the pitch range scan.
`default_nettype none
module hns_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hns_pkg::cell_cmd_type cmd,
   input  wire hns_pkg::entry_type    left_entry,
   input  wire logic                  left_hole,
   input  wire hns_pkg::entry_type    right_entry,
   input  wire hns_pkg::range_type    right_range,
   output hns_pkg::entry_type         entry,
   output logic                       hole,
   output hns_pkg::range_type         range,
   output logic                       hit
);

   logic                       used_ff, used_in;
   logic [hns_pkg::NOTE_W-1:0] note_ff, note_in;
   logic [hns_pkg::NOTE_W-1:0] vel_ff, vel_in;
   logic                       hole_ff, hole_in;
   hns_pkg::range_type         range_ff, range_in;

   assign entry = '{used: used_ff, note: note_ff, velocity: vel_ff};
   assign hole  = hole_ff;
   assign range = range_ff;
   assign hit   = used_ff && (note_ff == cmd.key);

   // Slot update: clear, match-and-punch, close the gap, push from the left
   always_comb begin
      used_in = used_ff;
      note_in = note_ff;
      vel_in  = vel_ff;
      hole_in = hole_ff;
      if (cmd.do_clear) begin
         used_in = 1'b0;
         hole_in = 1'b0;
      end else if (cmd.do_match) begin
         if (hit) begin
            used_in = 1'b0;
            hole_in = 1'b1;
         end
      end else if (cmd.do_shift) begin
         // gap travels one slot toward the tail each cycle
         hole_in = left_hole;
         if (hole_ff) begin
            used_in = right_entry.used;
            note_in = right_entry.note;
            vel_in  = right_entry.velocity;
         end
      end else if (cmd.do_push) begin
         used_in = left_entry.used;
         note_in = left_entry.note;
         vel_in  = left_entry.velocity;
      end
   end

   // Pitch range of this slot and everything behind it
   always_comb begin
      if (!used_ff) begin
         range_in = right_range;
      end else if (!right_range.any) begin
         range_in = '{any: 1'b1, lo: note_ff, hi: note_ff};
      end else begin
         range_in.any = 1'b1;
         range_in.lo  = (note_ff < right_range.lo) ? note_ff : right_range.lo;
         range_in.hi  = (note_ff > right_range.hi) ? note_ff : right_range.hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         hole_ff      <= 1'b0;
         range_ff.any <= 1'b0;
      end else begin
         used_ff      <= used_in;
         hole_ff      <= hole_in;
         range_ff.any <= range_in.any;
      end
   end

   always_ff @(posedge clock) begin
      note_ff     <= note_in;
      vel_ff      <= vel_in;
      range_ff.lo <= range_in.lo;
      range_ff.hi <= range_in.hi;
   end

endmodule
`default_nettype wire

// ===== rtl/core/hns_ctrl.sv =====
// Event sequencer: steps the cell chain through match, gap close, push and range scan.
`default_nettype none
module hns_ctrl #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [1:0]                 action,
   input  wire logic [hns_pkg::NOTE_W-1:0] note,
   input  wire logic [hns_pkg::NOTE_W-1:0] velocity,
   input  wire logic                       hit_any,
   input  wire hns_pkg::entry_type         head,
   input  wire hns_pkg::range_type         head_range,
   output logic                            busy,
   output hns_pkg::cell_cmd_type           cmd,
   output hns_pkg::rsp_type                rsp
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int STEP_W = $clog2(STACK_DEPTH);
   localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(STACK_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(STACK_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MATCH  = 6'b000010,
      ST_SHIFT  = 6'b000100,
      ST_PUSH   = 6'b001000,
      ST_SETTLE = 6'b010000,
      ST_DONE   = 6'b100000
   } ctrl_state_type;

   ctrl_state_type             state_ff, state_in;
   logic [1:0]                 action_ff, action_in;
   logic [hns_pkg::NOTE_W-1:0] key_ff, key_in;
   logic [hns_pkg::NOTE_W-1:0] vel_ff, vel_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   hns_pkg::rsp_type           rsp_ff, rsp_in;
   logic [CNT_W+hns_pkg::COUNT_OUT_W-1:0] count_wide;

   assign busy = (state_ff != ST_IDLE);
   assign rsp  = rsp_ff;
   assign count_wide = {{hns_pkg::COUNT_OUT_W{1'b0}}, count_ff};

   // Command to the cells
   always_comb begin
      cmd          = '0;
      cmd.key      = key_ff;
      cmd.velocity = vel_ff;
      if (state_ff == ST_MATCH) begin
         cmd.do_match = (action_ff == hns_pkg::ACT_NOTE_ON) ||
                        (action_ff == hns_pkg::ACT_NOTE_OFF);
         cmd.do_clear = (action_ff == hns_pkg::ACT_CLEAR);
      end
      cmd.do_shift = (state_ff == ST_SHIFT);
      cmd.do_push  = (state_ff == ST_PUSH);
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      key_in    = key_ff;
      vel_in    = vel_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      rsp_in    = rsp_ff;
      rsp_in.valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               action_in = action;
               key_in    = note;
               vel_in    = velocity;
               state_in  = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (cmd.do_clear) begin
               count_in = '0;
            end else if (cmd.do_match && hit_any) begin
               count_in = count_ff - CNT_W'(1);
            end
            step_in  = '0;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = (action_ff == hns_pkg::ACT_NOTE_ON) ? ST_PUSH : ST_SETTLE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_PUSH: begin
            // a full chain drops its tail, so the count holds
            if (count_ff != FULL_COUNT) begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DONE: begin
            rsp_in.valid           = 1'b1;
            rsp_in.held_count      = count_wide[hns_pkg::COUNT_OUT_W-1:0];
            rsp_in.is_empty        = (count_ff == '0);
            rsp_in.recent_note     = head.used ? head.note : '0;
            rsp_in.recent_velocity = head.used ? head.velocity : '0;
            rsp_in.lowest_note     = head_range.any ? head_range.lo : '0;
            rsp_in.highest_note    = head_range.any ? head_range.hi : '0;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_ff.valid <= rsp_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      action_ff              <= action_in;
      key_ff                 <= key_in;
      vel_ff                 <= vel_in;
      rsp_ff.held_count      <= rsp_in.held_count;
      rsp_ff.is_empty        <= rsp_in.is_empty;
      rsp_ff.recent_note     <= rsp_in.recent_note;
      rsp_ff.recent_velocity <= rsp_in.recent_velocity;
      rsp_ff.lowest_note     <= rsp_in.lowest_note;
      rsp_ff.highest_note    <= rsp_in.highest_note;
   end

endmodule
`default_nettype wire

// ===== bench/held_note_stack_checker.sv =====
// Watches the held note stack channels, predicts each status and compares.
`timescale 1ns / 1ps
module held_note_stack_checker #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire logic [1:0]                 req_action,
   input  wire logic [hns_pkg::NOTE_W-1:0] req_note,
   input  wire logic [hns_pkg::NOTE_W-1:0] req_velocity,
   input  wire logic                       rsp_valid,
   input  wire logic [hns_pkg::COUNT_OUT_W-1:0] rsp_held_count,
   input  wire logic                       rsp_is_empty,
   input  wire logic [hns_pkg::NOTE_W-1:0] rsp_recent_note,
   input  wire logic [hns_pkg::NOTE_W-1:0] rsp_recent_velocity,
   input  wire logic [hns_pkg::NOTE_W-1:0] rsp_lowest_note,
   input  wire logic [hns_pkg::NOTE_W-1:0] rsp_highest_note,
   output int                              fail_count,
   output int                              pending,
   output int                              evictions_seen,
   output int                              statuses_checked
);

   typedef logic [hns_pkg::COUNT_OUT_W-1:0] count_type;

   // Held keys in recency order, index 0 is the most recently pressed
   logic [hns_pkg::NOTE_W-1:0] held_notes[$];
   logic [hns_pkg::NOTE_W-1:0] held_velocities[$];
   // Predicted status per accepted transaction, oldest first
   hns_pkg::rsp_type expected_status[$];

   int mismatches = 0;
   int evictions  = 0;
   int checked    = 0;
   int event_no   = 0;

   // Release a key if it is held; no change otherwise
   function automatic void release_key(input logic [hns_pkg::NOTE_W-1:0] key);
      for (int i = 0; i < held_notes.size(); i++) begin
         if (held_notes[i] == key) begin
            held_notes.delete(i);
            held_velocities.delete(i);
            return;
         end
      end
   endfunction

   // Apply one key event to the held set and return the status it reports
   function automatic hns_pkg::rsp_type play_key_event(
         input logic [1:0]                 action,
         input logic [hns_pkg::NOTE_W-1:0] key,
         input logic [hns_pkg::NOTE_W-1:0] vel);
      hns_pkg::rsp_type st;
      logic [hns_pkg::NOTE_W-1:0] lo;
      logic [hns_pkg::NOTE_W-1:0] hi;
      st = '0;
      case (action)
         hns_pkg::ACT_NOTE_ON: begin
            // retrigger drops the old entry; a full stack loses its oldest key
            release_key(key);
            if (held_notes.size() >= STACK_DEPTH) begin
               held_notes.delete(held_notes.size() - 1);
               held_velocities.delete(held_velocities.size() - 1);
               evictions++;
            end
            held_notes.push_front(key);
            held_velocities.push_front(vel);
         end
         hns_pkg::ACT_NOTE_OFF: release_key(key);
         hns_pkg::ACT_CLEAR: begin
            held_notes.delete();
            held_velocities.delete();
         end
         default: ;
      endcase
      st.valid      = 1'b1;
      st.held_count = count_type'(held_notes.size());
      st.is_empty   = (held_notes.size() == 0);
      if (held_notes.size() > 0) begin
         lo = held_notes[0];
         hi = held_notes[0];
         for (int i = 1; i < held_notes.size(); i++) begin
            if (held_notes[i] < lo) lo = held_notes[i];
            if (held_notes[i] > hi) hi = held_notes[i];
         end
         st.recent_note     = held_notes[0];
         st.recent_velocity = held_velocities[0];
         st.lowest_note     = lo;
         st.highest_note    = hi;
      end
      return st;
   endfunction

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: status %0d %s expected %0d, got %0d", $time, event_no, what,
                  want, got);
         mismatches++;
      end
   endtask

   // Responses are retired before the transaction accepted on the same edge
   always @(posedge clock) begin : watch
      hns_pkg::rsp_type want;
      if (reset) begin
         held_notes.delete();
         held_velocities.delete();
         expected_status.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_status.size() == 0) begin
               $display("%0t: status with no transaction outstanding, count %0d",
                        $time, rsp_held_count);
               mismatches++;
            end else begin
               want = expected_status.pop_front();
               check_field("held_count", int'(want.held_count), int'(rsp_held_count));
               check_field("is_empty", int'(want.is_empty), int'(rsp_is_empty));
               check_field("recent_note", int'(want.recent_note),
                           int'(rsp_recent_note));
               check_field("recent_velocity", int'(want.recent_velocity),
                           int'(rsp_recent_velocity));
               check_field("lowest_note", int'(want.lowest_note),
                           int'(rsp_lowest_note));
               check_field("highest_note", int'(want.highest_note),
                           int'(rsp_highest_note));
               checked++;
               event_no++;
            end
         end
         if (start && !busy)
            expected_status.push_back(play_key_event(req_action, req_note, req_velocity));
      end
      fail_count       <= mismatches;
      pending          <= expected_status.size();
      evictions_seen   <= evictions;
      statuses_checked <= checked;
   end

endmodule

// ===== bench/tb_held_note_stack.sv =====
// Top of the held note stack bench: clock, reset, key event stimulus and verdict.
`timescale 1ns / 1ps
module tb_held_note_stack;

   localparam int STACK_DEPTH     = 16;
   localparam int EVENT_CYCLES    = 2 * STACK_DEPTH + 4;
   localparam int QUIET_LIMIT     = 1000;
   localparam int ITEMS_PER_PHASE = 442;
   localparam int MAX_GAP         = 60;
   // action code with no defined effect, reports the state only
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef logic [hns_pkg::NOTE_W-1:0] note_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [1:0]                      req_action;
   logic [hns_pkg::NOTE_W-1:0]      req_note;
   logic [hns_pkg::NOTE_W-1:0]      req_velocity;
   logic                            rsp_valid;
   logic [hns_pkg::COUNT_OUT_W-1:0] rsp_held_count;
   logic                            rsp_is_empty;
   logic [hns_pkg::NOTE_W-1:0]      rsp_recent_note;
   logic [hns_pkg::NOTE_W-1:0]      rsp_recent_velocity;
   logic [hns_pkg::NOTE_W-1:0]      rsp_lowest_note;
   logic [hns_pkg::NOTE_W-1:0]      rsp_highest_note;

   int fail_count;
   int pending;
   int evictions_seen;
   int statuses_checked;
   int sent_by_action[4];

   held_note_stack #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_note(req_note), .req_velocity(req_velocity),
      .rsp_valid(rsp_valid), .rsp_held_count(rsp_held_count),
      .rsp_is_empty(rsp_is_empty), .rsp_recent_note(rsp_recent_note),
      .rsp_recent_velocity(rsp_recent_velocity), .rsp_lowest_note(rsp_lowest_note),
      .rsp_highest_note(rsp_highest_note)
   );

   held_note_stack_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_note(req_note), .req_velocity(req_velocity),
      .rsp_valid(rsp_valid), .rsp_held_count(rsp_held_count),
      .rsp_is_empty(rsp_is_empty), .rsp_recent_note(rsp_recent_note),
      .rsp_recent_velocity(rsp_recent_velocity), .rsp_lowest_note(rsp_lowest_note),
      .rsp_highest_note(rsp_highest_note), .fail_count(fail_count),
      .pending(pending), .evictions_seen(evictions_seen),
      .statuses_checked(statuses_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Present one key event after an optional idle gap; returns once accepted
   task automatic send_key_event(input logic [1:0] action,
                                 input logic [hns_pkg::NOTE_W-1:0] key,
                                 input logic [hns_pkg::NOTE_W-1:0] vel, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start        <= 1'b1;
      req_action   <= action;
      req_note     <= key;
      req_velocity <= vel;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_by_action[action]++;
   endtask

   // Random play: phrases over a narrow key window so the stack fills and
   // retriggers, with stray keys, clears and the unused code as noise
   task automatic play_phase(input int idle_pct);
      int span;
      int base;
      int on_cut;
      int roll;
      int gap;
      logic [1:0] action;
      logic [hns_pkg::NOTE_W-1:0] key;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
         if (k % 60 == 0) begin
            case ($urandom_range(3))
               0: span = 4;
               1: span = 12;
               2: span = 20;
               default: span = 32;
            endcase
            base   = $urandom_range(128 - span);
            on_cut = $urandom_range(500, 760);
         end
         roll = $urandom_range(999);
         if (roll < 15)
            action = hns_pkg::ACT_CLEAR;
         else if (roll < 45)
            action = ACT_UNUSED;
         else if (roll < on_cut)
            action = hns_pkg::ACT_NOTE_ON;
         else
            action = hns_pkg::ACT_NOTE_OFF;
         if ($urandom_range(9) < 8)
            key = note_type'(base + $urandom_range(span - 1));
         else
            key = note_type'($urandom_range(127));
         // each cycle the sender idles with the given odds
         gap = 0;
         while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
         send_key_event(action, key, note_type'($urandom_range(127)), gap);
      end
   endtask

   // Stall detector: ends the run when no transaction moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid)
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      reset        = 1'b1;
      start        = 1'b0;
      req_action   = hns_pkg::ACT_NOTE_ON;
      req_note     = '0;
      req_velocity = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty stack, field extremes, retrigger, stray note off
      send_key_event(ACT_UNUSED, 7'd0, 7'd0, 0);
      send_key_event(hns_pkg::ACT_NOTE_OFF, 7'd127, 7'd127, 0);
      send_key_event(hns_pkg::ACT_NOTE_ON, 7'd0, 7'd127, 0);
      send_key_event(hns_pkg::ACT_NOTE_ON, 7'd127, 7'd0, 2);
      send_key_event(hns_pkg::ACT_NOTE_ON, 7'd85, 7'd42, 0);
      send_key_event(hns_pkg::ACT_NOTE_ON, 7'd0, 7'd85, 0);
      send_key_event(hns_pkg::ACT_NOTE_OFF, 7'd85, 7'd0, 0);
      send_key_event(hns_pkg::ACT_NOTE_OFF, 7'd42, 7'd0, 5);
      send_key_event(ACT_UNUSED, 7'd127, 7'd127, 0);
      // fill to capacity, then one more evicts the oldest key (the top note)
      for (int i = 0; i < STACK_DEPTH - 2; i++)
         send_key_event(hns_pkg::ACT_NOTE_ON, 7'(10 + i * 7), 7'(i * 9), 0);
      send_key_event(hns_pkg::ACT_NOTE_ON, 7'd55, 7'd99, 0);
      send_key_event(hns_pkg::ACT_CLEAR, 7'd0, 7'd0, 0);

      // Random: sender idling heavy, heavier, then back to back
      play_phase(36);
      play_phase(56);
      play_phase(0);

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (EVENT_CYCLES + 4) @(posedge clock);

      $display("Covered %0d note on, %0d note off, %0d clear, %0d unused-code events;",
               sent_by_action[hns_pkg::ACT_NOTE_ON], sent_by_action[hns_pkg::ACT_NOTE_OFF],
               sent_by_action[hns_pkg::ACT_CLEAR], sent_by_action[ACT_UNUSED]);
      $display("%0d statuses checked, %0d full-stack evictions, %0d mismatches.",
               statuses_checked, evictions_seen, fail_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
